>>> hw/rtl/sqpc_pkg.sv
package sqpc_pkg;

  localparam int unsigned STACK_DEPTH_DEF = 32;
  localparam int unsigned COUNT_WIDTH = 12;

  localparam logic signed [COUNT_WIDTH-1:0] CNT_MAX = {1'b0, {(COUNT_WIDTH-1){1'b1}}};
  localparam logic signed [COUNT_WIDTH-1:0] CNT_MIN = {1'b1, {(COUNT_WIDTH-1){1'b0}}};

  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_DQUOTE = 8'h22;

  localparam logic [2:0] ST_COMPLETE     = 3'd0;
  localparam logic [2:0] ST_AWAIT_PAREN  = 3'd1;
  localparam logic [2:0] ST_UNEXP_PAREN  = 3'd2;
  localparam logic [2:0] ST_AWAIT_SQUOTE = 3'd3;
  localparam logic [2:0] ST_AWAIT_DQUOTE = 3'd4;
  localparam logic [2:0] ST_OVERFLOW     = 3'd5;

  // stack entry kinds
  localparam logic CTX_PAREN  = 1'b0;
  localparam logic CTX_DQUOTE = 1'b1;

  typedef enum logic [2:0] {
    Q_NONE   = 3'b001,
    Q_SINGLE = 3'b010,
    Q_DOUBLE = 3'b100
  } quote_e;

  typedef struct packed {
    logic [7:0] ch;
    logic       last_byte;
  } in_req_t;

  typedef struct packed {
    logic [2:0]                    status;
    logic signed [COUNT_WIDTH-1:0] paren_balance;
  } out_rsp_t;

  typedef struct packed {
    logic single;
    logic esc;
    logic dol;
  } nest_flags_t;

  typedef struct packed {
    nest_flags_t flags;
    logic        push;
    logic        pop;
    logic        val;
    logic        inc;
    logic        dec;
  } nest_res_t;

  typedef struct packed {
    logic push;
    logic pop;
    logic clear;
    logic val;
  } stack_op_t;

  typedef struct packed {
    logic nonempty;
    logic full;
    logic tos;
  } stack_st_t;

  // one byte through a nested paren / double-quote context tracker
  function automatic nest_res_t nest_step(logic [7:0] c, nest_flags_t f,
                                          logic nonempty, logic tos);
    nest_res_t r;
    logic      skip;
    r       = '0;
    r.flags = f;
    skip    = 1'b0;
    if (f.single) begin
      if (f.esc) begin
        r.flags.esc = 1'b0;
        skip        = (c == CH_SQUOTE);
      end
      if (!skip) begin
        if (c == CH_SQUOTE) begin
          r.flags.single = 1'b0;
        end else if (c == CH_BSLASH) begin
          r.flags.esc = 1'b1;
        end
      end
    end else if (f.esc) begin
      r.flags.esc = 1'b0;
    end else if (f.dol) begin
      r.flags.dol = 1'b0;
      if (c == CH_LPAREN) begin
        r.push = 1'b1;
        r.val  = CTX_PAREN;
        r.inc  = 1'b1;
      end
    end else if (c == CH_BSLASH) begin
      r.flags.esc = 1'b1;
    end else if (nonempty && tos == CTX_DQUOTE) begin
      if (c == CH_DQUOTE) begin
        r.pop = 1'b1;
      end else if (c == CH_DOLLAR) begin
        r.flags.dol = 1'b1;
      end
    end else if (c == CH_DQUOTE) begin
      r.push = 1'b1;
      r.val  = CTX_DQUOTE;
    end else if (c == CH_LPAREN) begin
      r.push = 1'b1;
      r.val  = CTX_PAREN;
      r.inc  = 1'b1;
    end else if (c == CH_RPAREN) begin
      r.pop = nonempty;
      r.dec = 1'b1;
    end else if (c == CH_SQUOTE) begin
      r.flags.single = 1'b1;
    end
    return r;
  endfunction

endpackage

>>> hw/rtl/shell_quote_paren_closure_check.sv
// channel   | direction | handshake               | payload
// in        | input     | in_valid_i / in_ready_o  | in_data_i  (ch, last_byte)
// out       | output    | out_valid_o / out_ready_i | out_data_o (status, paren_balance)
//
// one byte per cycle; a result appears the cycle after a last byte is taken
// each byte touches only the top of two context stacks, each a one-port-read
// memory with the entry below the top fetched ahead into a register
// reset is asynchronous active low and needs no clearing pass; tracker state also
// returns to reset after each last byte
// input stalls only while a result is held and out_ready_i is low
module shell_quote_paren_closure_check
  import sqpc_pkg::*;
#(
  parameter int unsigned STACK_DEPTH = STACK_DEPTH_DEF
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  in_req_t  in_data_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output out_rsp_t out_data_o
);

  logic                          accept, line_end;
  logic [7:0]                    ch;
  nest_flags_t                   bal_flags_q, bal_flags_d;
  nest_flags_t                   quo_flags_q, quo_flags_d;
  nest_res_t                     bal_res, quo_res;
  quote_e                        top_quote_q, top_quote_d;
  logic signed [COUNT_WIDTH-1:0] count_q, count_d;
  logic                          overflow_q, overflow_d;
  stack_op_t                     bal_op, quo_op;
  stack_st_t                     bal_st, quo_st;
  logic                          quo_push, quo_pop, quo_val;
  logic                          out_valid_q, out_valid_d;
  out_rsp_t                      out_data_q, out_data_d;
  logic [2:0]                    status;

  assign ch         = in_data_i.ch;
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;
  assign line_end   = accept && in_data_i.last_byte;

  // paren tracker
  always_comb begin
    bal_res     = nest_step(ch, bal_flags_q, bal_st.nonempty, bal_st.tos);
    bal_flags_d = bal_res.flags;
    count_d     = count_q;
    if (bal_res.inc && count_q != CNT_MAX) begin
      count_d = count_q + COUNT_WIDTH'(1);
    end else if (bal_res.dec && count_q != CNT_MIN) begin
      count_d = count_q - COUNT_WIDTH'(1);
    end
  end

  // quote tracker
  always_comb begin
    quo_res     = nest_step(ch, quo_flags_q, quo_st.nonempty, quo_st.tos);
    quo_flags_d = quo_flags_q;
    top_quote_d = top_quote_q;
    quo_push    = 1'b0;
    quo_pop     = 1'b0;
    quo_val     = CTX_PAREN;
    case (top_quote_q)
      Q_NONE: begin
        if (quo_flags_q.esc) begin
          quo_flags_d.esc = 1'b0;
        end else if (ch == CH_BSLASH) begin
          quo_flags_d.esc = 1'b1;
        end else if (ch == CH_SQUOTE) begin
          top_quote_d = Q_SINGLE;
        end else if (ch == CH_DQUOTE) begin
          top_quote_d = Q_DOUBLE;
        end
      end
      Q_SINGLE: begin
        if (quo_flags_q.esc) begin
          quo_flags_d.esc = 1'b0;
        end
        // an escaped quote stays inside
        if (!(quo_flags_q.esc && ch == CH_SQUOTE)) begin
          if (ch == CH_SQUOTE) begin
            top_quote_d = Q_NONE;
          end else if (ch == CH_BSLASH) begin
            quo_flags_d.esc = 1'b1;
          end
        end
      end
      Q_DOUBLE: begin
        if (quo_st.nonempty) begin
          quo_flags_d = quo_res.flags;
          quo_push    = quo_res.push;
          quo_pop     = quo_res.pop;
          quo_val     = quo_res.val;
        end else if (quo_flags_q.esc) begin
          quo_flags_d.esc = 1'b0;
        end else if (quo_flags_q.dol) begin
          quo_flags_d.dol = 1'b0;
          quo_push        = (ch == CH_LPAREN);
        end else if (ch == CH_BSLASH) begin
          quo_flags_d.esc = 1'b1;
        end else if (ch == CH_DQUOTE) begin
          top_quote_d = Q_NONE;
        end else if (ch == CH_DOLLAR) begin
          quo_flags_d.dol = 1'b1;
        end
      end
      default: begin
        top_quote_d = Q_NONE;
      end
    endcase
  end

  always_comb begin
    bal_op.push  = accept && bal_res.push;
    bal_op.pop   = accept && bal_res.pop;
    bal_op.clear = line_end;
    bal_op.val   = bal_res.val;
    quo_op.push  = accept && quo_push;
    quo_op.pop   = accept && quo_pop;
    quo_op.clear = line_end;
    quo_op.val   = quo_val;
  end

  assign overflow_d = overflow_q || (bal_op.push && bal_st.full) ||
                      (quo_op.push && quo_st.full);

  sqpc_stack #(
    .STACK_DEPTH(STACK_DEPTH)
  ) u_bal_stack (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .op_i  (bal_op),
    .st_o  (bal_st)
  );

  sqpc_stack #(
    .STACK_DEPTH(STACK_DEPTH)
  ) u_quo_stack (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .op_i  (quo_op),
    .st_o  (quo_st)
  );

  always_comb begin
    if (overflow_d) begin
      status = ST_OVERFLOW;
    end else if (count_d > 0) begin
      status = ST_AWAIT_PAREN;
    end else if (count_d < 0) begin
      status = ST_UNEXP_PAREN;
    end else if (top_quote_d == Q_SINGLE) begin
      status = ST_AWAIT_SQUOTE;
    end else if (top_quote_d == Q_DOUBLE) begin
      status = ST_AWAIT_DQUOTE;
    end else begin
      status = ST_COMPLETE;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    if (line_end) begin
      out_valid_d              = 1'b1;
      out_data_d.status        = status;
      out_data_d.paren_balance = count_d;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bal_flags_q <= '0;
      quo_flags_q <= '0;
      top_quote_q <= Q_NONE;
      count_q     <= '0;
      overflow_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (line_end) begin
        bal_flags_q <= '0;
        quo_flags_q <= '0;
        top_quote_q <= Q_NONE;
        count_q     <= '0;
        overflow_q  <= 1'b0;
      end else if (accept) begin
        bal_flags_q <= bal_flags_d;
        quo_flags_q <= quo_flags_d;
        top_quote_q <= top_quote_d;
        count_q     <= count_d;
        overflow_q  <= overflow_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

>>> hw/rtl/sqpc_stack.sv
module sqpc_stack
  import sqpc_pkg::*;
#(
  parameter int unsigned STACK_DEPTH = STACK_DEPTH_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  stack_op_t op_i,
  output stack_st_t st_o
);

  localparam int unsigned DW = $clog2(STACK_DEPTH + 1);
  localparam int unsigned AW = $clog2(STACK_DEPTH);

  logic          mem_q [STACK_DEPTH];
  logic [DW-1:0] depth_q, depth_d;
  logic          tos_q, tos_d;
  logic          nos_q;
  logic          full, nonempty;
  logic          do_push, do_pop;
  logic [DW-1:0] rd_ptr;
  logic [AW-1:0] raddr, waddr;

  assign full     = (depth_q == DW'(STACK_DEPTH));
  assign nonempty = (depth_q != '0);
  assign do_push  = op_i.push && !full;
  assign do_pop   = op_i.pop && nonempty;

  always_comb begin
    depth_d = depth_q;
    tos_d   = tos_q;
    if (op_i.clear) begin
      depth_d = '0;
    end else if (do_push) begin
      depth_d = depth_q + DW'(1);
      tos_d   = op_i.val;
    end else if (do_pop) begin
      depth_d = depth_q - DW'(1);
      tos_d   = nos_q;
    end
  end

  // the entry below the new top is fetched every cycle; it never equals the
  // address being pushed, so no forwarding is needed
  assign rd_ptr = depth_d - DW'(2);
  assign raddr  = rd_ptr[AW-1:0];
  assign waddr  = depth_q[AW-1:0];

  always_ff @(posedge clk_i) begin
    if (do_push && !op_i.clear) begin
      mem_q[waddr] <= op_i.val;
    end
    nos_q <= mem_q[raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      depth_q <= '0;
      tos_q   <= 1'b0;
    end else begin
      depth_q <= depth_d;
      tos_q   <= tos_d;
    end
  end

  assign st_o.nonempty = nonempty;
  assign st_o.full     = full;
  assign st_o.tos      = tos_q;

endmodule

>>> hw/rtl/sqpc_checker.sv
module sqpc_checker
  import sqpc_pkg::*;
(
  input logic     clk_i,
  input logic     rst_ni,
  input logic     in_valid_i,
  input logic     in_ready_o,
  input in_req_t  in_data_i,
  input logic     out_valid_o,
  input logic     out_ready_i,
  input out_rsp_t out_data_o
);

  // a held result stays put until taken
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result dropped or changed while stalled");

  // a last byte yields a result on the next cycle
  a_last_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && in_data_i.last_byte |=> out_valid_o)
    else $error("no result after last byte");

  a_status_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.status <= ST_OVERFLOW)
    else $error("status code out of range");

  // status and balance agree unless overflow takes priority
  a_complete_balanced: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.status == ST_COMPLETE ||
                    out_data_o.status == ST_AWAIT_SQUOTE ||
                    out_data_o.status == ST_AWAIT_DQUOTE)
    |-> out_data_o.paren_balance == '0)
    else $error("quote status with non-zero balance");

  a_paren_sign: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.status == ST_AWAIT_PAREN
    |-> out_data_o.paren_balance > 0)
    else $error("await paren with non-positive balance");

endmodule

bind shell_quote_paren_closure_check sqpc_checker u_sqpc_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_valid_i),
  .in_ready_o (in_ready_o),
  .in_data_i  (in_data_i),
  .out_valid_o(out_valid_o),
  .out_ready_i(out_ready_i),
  .out_data_o (out_data_o)
);

>>> sim/tb.sv
module tb;
  import sqpc_pkg::*;

  localparam int DEPTH     = STACK_DEPTH_DEF;
  localparam int CW        = COUNT_WIDTH;
  localparam int QUIET_MAX = 4000;
  localparam int RAND_BYTES = 430;

  logic     clk_i = 1'b0;
  logic     rst_ni = 1'b0;
  logic     in_valid = 1'b0;
  logic     in_ready;
  in_req_t  in_data = '0;
  logic     out_valid;
  logic     out_ready = 1'b0;
  out_rsp_t out_data;

  shell_quote_paren_closure_check dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_data_o (out_data)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // shadow tracker state: index 0 is the paren tracker, 1 the quote tracker's nest
  logic        ctx_stk [2][DEPTH];
  int unsigned ctx_dep [2];
  logic        in_sq [2];
  logic        esc_pend [2];
  logic        dol_pend [2];
  int          balance;
  quote_e      top_q;
  logic        stack_full_hit;

  in_req_t     byte_q [$];
  out_rsp_t    line_verdicts [$];
  logic [7:0]  line_buf [$];
  int          mismatches = 0;
  int          rand_bytes = 0;

  function automatic void clear_trackers();
    for (int t = 0; t < 2; t++) begin
      for (int i = 0; i < DEPTH; i++) ctx_stk[t][i] = CTX_PAREN;
      ctx_dep[t]  = 0;
      in_sq[t]    = 1'b0;
      esc_pend[t] = 1'b0;
      dol_pend[t] = 1'b0;
    end
    balance        = 0;
    top_q          = Q_NONE;
    stack_full_hit = 1'b0;
  endfunction

  function automatic void push_ctx(int t, logic kind);
    if (ctx_dep[t] < DEPTH) begin
      ctx_stk[t][ctx_dep[t]] = kind;
      ctx_dep[t]++;
    end else begin
      stack_full_hit = 1'b1;
    end
  endfunction

  // returns +1 for an opened paren, -1 for a closed one
  function automatic int nest_byte(int t, logic [7:0] c);
    logic in_dq;
    if (in_sq[t]) begin
      if (esc_pend[t]) begin
        esc_pend[t] = 1'b0;
        if (c == CH_SQUOTE) return 0;
      end
      if (c == CH_SQUOTE) in_sq[t] = 1'b0;
      else if (c == CH_BSLASH) esc_pend[t] = 1'b1;
      return 0;
    end
    if (esc_pend[t]) begin
      esc_pend[t] = 1'b0;
      return 0;
    end
    if (dol_pend[t]) begin
      dol_pend[t] = 1'b0;
      if (c == CH_LPAREN) begin
        push_ctx(t, CTX_PAREN);
        return 1;
      end
      return 0;
    end
    if (c == CH_BSLASH) begin
      esc_pend[t] = 1'b1;
      return 0;
    end
    in_dq = (ctx_dep[t] > 0) ? ctx_stk[t][ctx_dep[t] - 1] : CTX_PAREN;
    if (in_dq == CTX_DQUOTE) begin
      if (c == CH_DQUOTE) ctx_dep[t]--;
      else if (c == CH_DOLLAR) dol_pend[t] = 1'b1;
      return 0;
    end
    if (c == CH_DQUOTE) begin
      push_ctx(t, CTX_DQUOTE);
    end else if (c == CH_LPAREN) begin
      push_ctx(t, CTX_PAREN);
      return 1;
    end else if (c == CH_RPAREN) begin
      if (ctx_dep[t] > 0) ctx_dep[t]--;
      return -1;
    end else if (c == CH_SQUOTE) begin
      in_sq[t] = 1'b1;
    end
    return 0;
  endfunction

  function automatic void quote_byte(logic [7:0] c);
    int unused;
    case (top_q)
      Q_NONE: begin
        if (esc_pend[1]) esc_pend[1] = 1'b0;
        else if (c == CH_BSLASH) esc_pend[1] = 1'b1;
        else if (c == CH_SQUOTE) top_q = Q_SINGLE;
        else if (c == CH_DQUOTE) top_q = Q_DOUBLE;
      end
      Q_SINGLE: begin
        if (esc_pend[1]) begin
          esc_pend[1] = 1'b0;
          if (c == CH_SQUOTE) return;
        end
        if (c == CH_SQUOTE) top_q = Q_NONE;
        else if (c == CH_BSLASH) esc_pend[1] = 1'b1;
      end
      default: begin
        if (ctx_dep[1] > 0) begin
          unused = nest_byte(1, c);
        end else if (esc_pend[1]) begin
          esc_pend[1] = 1'b0;
        end else if (dol_pend[1]) begin
          dol_pend[1] = 1'b0;
          if (c == CH_LPAREN) push_ctx(1, CTX_PAREN);
        end else if (c == CH_BSLASH) begin
          esc_pend[1] = 1'b1;
        end else if (c == CH_DQUOTE) begin
          top_q = Q_NONE;
        end else if (c == CH_DOLLAR) begin
          dol_pend[1] = 1'b1;
        end
      end
    endcase
  endfunction

  // advance the shadow trackers by one request, queue the verdict on a last byte
  function automatic void track_byte(in_req_t r);
    int       delta;
    out_rsp_t v;
    delta = nest_byte(0, r.ch);
    if (delta > 0 && balance < 2 ** (CW - 1) - 1) balance++;
    else if (delta < 0 && balance > -(2 ** (CW - 1))) balance--;
    quote_byte(r.ch);
    if (r.last_byte) begin
      if (stack_full_hit) v.status = ST_OVERFLOW;
      else if (balance > 0) v.status = ST_AWAIT_PAREN;
      else if (balance < 0) v.status = ST_UNEXP_PAREN;
      else if (top_q == Q_SINGLE) v.status = ST_AWAIT_SQUOTE;
      else if (top_q == Q_DOUBLE) v.status = ST_AWAIT_DQUOTE;
      else v.status = ST_COMPLETE;
      v.paren_balance = balance[CW-1:0];
      line_verdicts.push_back(v);
      clear_trackers();
    end
  endfunction

  // ---------------------------------------------------------------- stimulus

  function automatic logic [7:0] plain_char();
    return (($urandom_range(0, 4) == 0) ? 8'h20 : 8'h61 + 8'($urandom_range(0, 25)));
  endfunction

  function automatic logic [7:0] special_char();
    case ($urandom_range(0, 8))
      0: return CH_LPAREN;
      1: return CH_RPAREN;
      2: return CH_DOLLAR;
      3: return CH_BSLASH;
      4: return CH_SQUOTE;
      5: return CH_DQUOTE;
      6: return plain_char();
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic put(logic [7:0] c);
    line_buf.push_back(c);
  endtask

  task automatic queue_line();
    in_req_t r;
    for (int i = 0; i < line_buf.size(); i++) begin
      r.ch        = line_buf[i];
      r.last_byte = (i == line_buf.size() - 1);
      byte_q.push_back(r);
    end
    line_buf.delete();
  endtask

  task automatic add_text(string s);
    for (int i = 0; i < s.len(); i++) put(s[i]);
    queue_line();
  endtask

  task automatic add_run(logic [7:0] c, int n);
    for (int i = 0; i < n; i++) put(c);
    queue_line();
  endtask

  task automatic gen_dq_body(int lvl);
    int n;
    n = $urandom_range(0, 4);
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 5))
        0: begin
          put(CH_DOLLAR); put(CH_LPAREN);
          if (lvl < 5) gen_words(lvl + 1);
          put(CH_RPAREN);
        end
        1: begin put(CH_DOLLAR); put(8'($urandom_range(0, 255))); end
        2: begin put(CH_BSLASH); put(8'($urandom_range(0, 255))); end
        3: put(CH_SQUOTE);
        default: put(plain_char());
      endcase
    end
  endtask

  task automatic gen_words(int lvl);
    int n;
    n = $urandom_range(1, 4);
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 6))
        0: begin
          put(CH_LPAREN);
          if (lvl < 5) gen_words(lvl + 1);
          put(CH_RPAREN);
        end
        1: begin put(CH_DQUOTE); gen_dq_body(lvl); put(CH_DQUOTE); end
        2: begin
          put(CH_SQUOTE); put(plain_char());
          if ($urandom_range(0, 2) == 0) begin put(CH_BSLASH); put(CH_SQUOTE); end
          put(CH_SQUOTE);
        end
        3: begin put(CH_BSLASH); put(8'($urandom_range(0, 255))); end
        4: begin
          put(CH_DOLLAR); put(CH_LPAREN);
          if (lvl < 5) gen_words(lvl + 1);
          put(CH_RPAREN);
        end
        default: put(plain_char());
      endcase
    end
  endtask

  task automatic add_random_line();
    int k;
    case ($urandom_range(0, 9))
      0, 1, 2: begin
        // noise
        k = $urandom_range(1, 20);
        for (int i = 0; i < k; i++) put(special_char());
      end
      3: begin
        // deep nesting around the stack limit, sometimes inside a double quote
        k = $urandom_range(DEPTH - 4, DEPTH + 3);
        if ($urandom_range(0, 1)) begin put(CH_DQUOTE); put(CH_DOLLAR); end
        for (int i = 0; i < k; i++) put(($urandom_range(0, 3) == 0) ? CH_DQUOTE : CH_LPAREN);
        k = $urandom_range(0, k + 2);
        for (int i = 0; i < k; i++) put(($urandom_range(0, 3) == 0) ? CH_DQUOTE : CH_RPAREN);
      end
      default: begin
        gen_words(0);
        // break a well-formed line now and then
        if ($urandom_range(0, 3) == 0) begin
          k = $urandom_range(0, line_buf.size() - 1);
          line_buf[k] = special_char();
        end
      end
    endcase
    if (line_buf.size() == 0) put(plain_char());
    rand_bytes += line_buf.size();
    queue_line();
  endtask

  // ---------------------------------------------------------------- driver

  int  gap_left = 0;
  logic calm = 1'b0;
  logic noisy = 1'b1;

  always @(posedge clk_i) begin : drive_p
    logic took;
    took = in_valid && in_ready;
    if (rst_ni) begin
      if (took) begin
        track_byte(in_data);
        void'(byte_q.pop_front());
      end
      calm <= (byte_q.size() < 150);
      if ($urandom_range(0, 149) == 0) noisy <= !noisy;
      if (!in_valid || took) begin
        if (byte_q.size() == 0) begin
          in_valid <= 1'b0;
        end else if (gap_left > 0 && !calm) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (noisy && !calm && $urandom_range(0, 5) == 0) begin
          gap_left = $urandom_range(0, 3);
          in_valid <= 1'b0;
        end else begin
          in_valid <= 1'b1;
          in_data  <= byte_q[0];
        end
      end
    end
  end

  // ---------------------------------------------------------------- monitor

  int stall_left = 0;

  always @(posedge clk_i) begin : watch_p
    out_rsp_t want;
    if (rst_ni) begin
      if (out_valid && out_ready) begin
        if (line_verdicts.size() == 0) begin
          $display("%0t: result with none expected, got status %0d balance %0d",
                   $time, out_data.status, out_data.paren_balance);
          mismatches++;
        end else begin
          want = line_verdicts.pop_front();
          if (out_data.status !== want.status) begin
            $display("%0t: status expected %0d got %0d", $time, want.status,
                     out_data.status);
            mismatches++;
          end
          if (out_data.paren_balance !== want.paren_balance) begin
            $display("%0t: paren_balance expected %0d got %0d", $time,
                     want.paren_balance, out_data.paren_balance);
            mismatches++;
          end
        end
      end
      if (calm) begin
        out_ready <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else if (noisy && $urandom_range(0, 4) == 0) begin
        stall_left = $urandom_range(0, 3);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------- watchdog

  int quiet = 0;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        quiet <= 0;
      end else if (quiet >= QUIET_MAX) begin
        $display("tb: failure");
        $finish;
      end else begin
        quiet <= quiet + 1;
      end
    end
  end

  // ---------------------------------------------------------------- sequence

  initial begin
    clear_trackers();

    add_text("a");
    add_text("(");
    add_text(")");
    add_text("'");
    add_text("\"");
    add_text("(a)\"b\"'c'");
    add_text("\"$(\"");
    add_text("\"$(x)\"");
    add_text("\"$a\"");
    add_text("\\(");
    add_text("'\\''");
    add_text("\"$");
    add_text("\\");
    add_text("\"(\"'\"'");
    add_text("(\"x)\"");
    add_text("))(");
    put(8'h00); put(8'hFF); queue_line();
    put(8'hFF); queue_line();
    // stack overflow on both trackers
    add_run(CH_LPAREN, DEPTH + 1);
    put(CH_DQUOTE); put(CH_DOLLAR);
    for (int i = 0; i < DEPTH + 1; i++) put(CH_LPAREN);
    queue_line();

    while (rand_bytes < RAND_BYTES) add_random_line();

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    @(posedge clk_i);
    while (byte_q.size() > 0 || in_valid || line_verdicts.size() > 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
